[rtl/error_diffusion_palette_quantizer_macros.svh]
// ----------------------------------------------------------------------------
// error diffusion palette quantizer: assertion macros
// checks are compiled in simulation and drop out when SYNTHESIS is set
// ----------------------------------------------------------------------------
`ifndef ERROR_DIFFUSION_PALETTE_QUANTIZER_MACROS_SVH
`define ERROR_DIFFUSION_PALETTE_QUANTIZER_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define EDPQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("edpq assertion failed");

// condition must never be seen at a clock edge outside reset
`define EDPQ_NEVER(lbl, clk, rst_n, cond) \
  `EDPQ_ASSERT(lbl, clk, rst_n, !(cond))

`else

`define EDPQ_ASSERT(lbl, clk, rst_n, prop)
`define EDPQ_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

[rtl/edpq_pkg.sv]
// ----------------------------------------------------------------------------
// edpq_pkg
// shared types and constants of the error diffusion palette quantizer
// ----------------------------------------------------------------------------
package edpq_pkg;

  localparam int CH_W      = 8;   // one color channel
  localparam int INDEX_W   = 8;   // palette index
  localparam int FW_W      = 12;  // frame width register
  localparam int CFG_IDX_W = 1;   // register index on the config port

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DITHER_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 1'd1;

  localparam logic            DITHER_RESET      = 1'b1;
  localparam logic [FW_W-1:0] FRAME_WIDTH_RESET = 12'd640;

  // index = red level * 36 + green level * 6 + blue level
  localparam logic [INDEX_W-1:0] RED_WEIGHT   = 8'd36;
  localparam logic [INDEX_W-1:0] GREEN_WEIGHT = 8'd6;
  localparam logic [INDEX_W-1:0] MAX_INDEX    = 8'd215;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  // position class of an item, decided at the front
  typedef struct packed {
    logic first_row;  // nothing comes from the row above
    logic has_left;   // left and upper-left neighbors exist
    logic has_ur;     // upper-right neighbor exists
  } flags_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

[rtl/edpq_ram.sv]
// ----------------------------------------------------------------------------
// edpq_ram
// generic ram, one write port and two registered read ports, read-old
// ----------------------------------------------------------------------------
module edpq_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

[rtl/edpq_fifo.sv]
// ----------------------------------------------------------------------------
// edpq_fifo
// small register queue between the front and the back
// ----------------------------------------------------------------------------
module edpq_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic [WIDTH-1:0]       data_i,
  input  logic                   pop_i,
  output logic [WIDTH-1:0]       data_o,
  output edpq_pkg::fifo_status_t status_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign status_o.empty = (cnt_q == '0);

endmodule

[rtl/edpq_front.sv]
// ----------------------------------------------------------------------------
// edpq_front
// accepts pixels, tracks column and first row, classifies row edges
// ----------------------------------------------------------------------------
module edpq_front #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [edpq_pkg::FW_W-1:0]     frame_width_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          start_of_frame_i,
  input  edpq_pkg::pix_t                pix_i,
  input  logic                          queue_full_i,
  output logic                          push_o,
  output edpq_pkg::pix_t                push_pix_o,
  output edpq_pkg::flags_t              push_flags_o,
  output logic [$clog2(MAX_WIDTH)-1:0]  push_col_o
);

  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int CMP_W  = (ADDR_W + 1 > edpq_pkg::FW_W) ? ADDR_W + 1 : edpq_pkg::FW_W;

  logic [ADDR_W-1:0] col_q, col_d;
  logic              first_q, first_d;
  logic [ADDR_W-1:0] start_col, cur_col;
  logic              start_first, cur_first;
  logic [CMP_W-1:0]  fw_ext, w_eff, next_ext;
  logic              accept, wrap, has_ur;

  always_comb begin
    accept = in_valid_i && !queue_full_i;

    // width of zero acts as one, above the store depth as the depth
    fw_ext = CMP_W'(frame_width_i);
    if (fw_ext == '0) begin
      w_eff = CMP_W'(1);
    end else if (fw_ext > CMP_W'(MAX_WIDTH)) begin
      w_eff = CMP_W'(MAX_WIDTH);
    end else begin
      w_eff = fw_ext;
    end

    start_col   = start_of_frame_i ? '0 : col_q;
    start_first = start_of_frame_i ? 1'b1 : first_q;

    // width shrank mid-row: start a new row
    wrap      = CMP_W'(start_col) >= w_eff;
    cur_col   = wrap ? '0 : start_col;
    cur_first = wrap ? 1'b0 : start_first;

    next_ext = CMP_W'(cur_col) + CMP_W'(1);
    has_ur   = next_ext < w_eff;

    col_d   = col_q;
    first_d = first_q;
    if (accept) begin
      if (has_ur) begin
        col_d   = cur_col + ADDR_W'(1);
        first_d = cur_first;
      end else begin
        col_d   = '0;
        first_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      first_q <= 1'b1;
    end else begin
      col_q   <= col_d;
      first_q <= first_d;
    end
  end

  assign in_stall_o             = queue_full_i;
  assign push_o                 = accept;
  assign push_pix_o             = pix_i;
  assign push_col_o             = cur_col;
  assign push_flags_o.first_row = cur_first;
  assign push_flags_o.has_left  = (cur_col != '0);
  assign push_flags_o.has_ur    = has_ur;

endmodule

[rtl/edpq_back.sv]
// ----------------------------------------------------------------------------
// edpq_back
// row error store, error diffusion, quantizer and output register
// ----------------------------------------------------------------------------
module edpq_back #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              dither_enable_i,
  input  logic                              q_empty_i,
  input  edpq_pkg::pix_t                    q_pix_i,
  input  edpq_pkg::flags_t                  q_flags_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]      q_col_i,
  output logic                              q_pop_o,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output logic [edpq_pkg::INDEX_W-1:0]      palette_index_o
);

  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int FLD_W  = 6;            // one channel error, two's complement
  localparam int ERR_W  = 3 * FLD_W;    // red, green, blue from the low end

  localparam logic [2:0] SPREAD_RIGHT = 3'd7;
  localparam logic [2:0] SPREAD_BELOW = 3'd5;
  localparam logic [2:0] SPREAD_BL    = 3'd3;
  localparam logic [2:0] SPREAD_BR    = 3'd1;

  localparam logic [7:0] LEVEL_THRESH [5] = '{8'd26, 8'd76, 8'd128, 8'd178, 8'd230};

  // weighted error / 16, rounded toward zero
  function automatic logic signed [4:0] spread(input logic [FLD_W-1:0] f,
                                               input logic [2:0] k);
    logic signed [9:0] p;
    logic signed [9:0] q;
    p = $signed({{4{f[FLD_W-1]}}, f}) * $signed({7'b0, k});
    if (p < 0) begin
      q = (p + 10'sd15) >>> 4;
    end else begin
      q = p >>> 4;
    end
    return q[4:0];
  endfunction

  function automatic logic [7:0] add_clamp(input logic [7:0] v,
                                           input logic signed [4:0] c);
    logic signed [9:0] s;
    s = $signed({2'b00, v}) + $signed({{5{c[4]}}, c});
    if (s < 0) begin
      return 8'd0;
    end else if (s > 10'sd255) begin
      return 8'd255;
    end
    return s[7:0];
  endfunction

  function automatic logic [2:0] level_of(input logic [7:0] v);
    logic [2:0] n;
    n = 3'd0;
    for (int i = 0; i < 5; i++) begin
      if (v > LEVEL_THRESH[i]) n = n + 3'd1;
    end
    return n;
  endfunction

  function automatic logic [7:0] level_value(input logic [2:0] lv);
    logic [7:0] r;
    case (lv)
      3'd0:    r = 8'd0;
      3'd1:    r = 8'd51;
      3'd2:    r = 8'd102;
      3'd3:    r = 8'd153;
      3'd4:    r = 8'd204;
      default: r = 8'd255;
    endcase
    return r;
  endfunction

  logic                   e_valid_q, e_valid_d;
  logic                   fwd_q, fwd_d;
  edpq_pkg::pix_t         e_pix_q;
  edpq_pkg::flags_t       e_flags_q;
  logic [ADDR_W-1:0]      e_col_q;
  logic [ADDR_W-1:0]      last_col_q;
  logic [ERR_W-1:0]       left_err_q, left_err_d;
  logic [ERR_W-1:0]       ul_err_q, ul_err_d;
  logic                   out_valid_q, out_valid_d;
  logic [edpq_pkg::INDEX_W-1:0] index_q, index_d;

  logic                   e_go, pop;
  logic [ADDR_W-1:0]      q_ur_col, ur_col;
  logic [ERR_W-1:0]       rd_up, rd_ur, up_word, ur_word, new_err;

  always_comb begin
    e_go     = e_valid_q && (!out_valid_q || !out_stall_i);
    pop      = !q_empty_i && (!e_valid_q || e_go);
    q_ur_col = q_flags_i.has_ur ? q_col_i + ADDR_W'(1) : q_col_i;
    ur_col   = e_col_q + ADDR_W'(1);

    // the item ahead writes the store at the edge this item reads it
    up_word = (fwd_q && (last_col_q == e_col_q)) ? left_err_q : rd_up;
    ur_word = (fwd_q && (last_col_q == ur_col)) ? left_err_q : rd_ur;
  end

  always_comb begin : p_chan
    logic [7:0]        chan [3];
    logic [2:0]        lv   [3];
    logic [7:0]        v;
    logic signed [8:0] e;
    chan[0] = e_pix_q.red;
    chan[1] = e_pix_q.green;
    chan[2] = e_pix_q.blue;
    new_err = '0;
    for (int c = 0; c < 3; c++) begin
      v = chan[c];
      if (dither_enable_i) begin
        if (!e_flags_q.first_row) begin
          if (e_flags_q.has_left) begin
            v = add_clamp(v, spread(ul_err_q[c*FLD_W +: FLD_W], SPREAD_BR));
          end
          v = add_clamp(v, spread(up_word[c*FLD_W +: FLD_W], SPREAD_BELOW));
          if (e_flags_q.has_ur) begin
            v = add_clamp(v, spread(ur_word[c*FLD_W +: FLD_W], SPREAD_BL));
          end
        end
        if (e_flags_q.has_left) begin
          v = add_clamp(v, spread(left_err_q[c*FLD_W +: FLD_W], SPREAD_RIGHT));
        end
      end
      lv[c] = level_of(v);
      e = $signed({1'b0, v}) - $signed({1'b0, level_value(lv[c])});
      new_err[c*FLD_W +: FLD_W] = dither_enable_i ? e[FLD_W-1:0] : '0;
    end
    index_d = edpq_pkg::INDEX_W'(lv[0]) * edpq_pkg::RED_WEIGHT
            + edpq_pkg::INDEX_W'(lv[1]) * edpq_pkg::GREEN_WEIGHT
            + edpq_pkg::INDEX_W'(lv[2]);
  end

  always_comb begin
    e_valid_d   = e_valid_q;
    fwd_d       = fwd_q;
    left_err_d  = left_err_q;
    ul_err_d    = ul_err_q;
    out_valid_d = out_valid_q;
    if (pop) begin
      e_valid_d = 1'b1;
      fwd_d     = e_go;
    end else if (e_go) begin
      e_valid_d = 1'b0;
    end
    if (e_go) begin
      left_err_d  = new_err;
      ul_err_d    = up_word;
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q   <= 1'b0;
      fwd_q       <= 1'b0;
      left_err_q  <= '0;
      ul_err_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      e_valid_q   <= e_valid_d;
      fwd_q       <= fwd_d;
      left_err_q  <= left_err_d;
      ul_err_q    <= ul_err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      e_pix_q   <= q_pix_i;
      e_flags_q <= q_flags_i;
      e_col_q   <= q_col_i;
    end
    if (e_go) begin
      last_col_q <= e_col_q;
      index_q    <= index_d;
    end
  end

  edpq_ram #(
    .WIDTH (ERR_W),
    .DEPTH (MAX_WIDTH)
  ) u_row_store (
    .clk_i     (clk_i),
    .we_i      (e_go),
    .waddr_i   (e_col_q),
    .wdata_i   (new_err),
    .re_i      (pop),
    .raddr_a_i (q_col_i),
    .raddr_b_i (q_ur_col),
    .rdata_a_o (rd_up),
    .rdata_b_o (rd_ur)
  );

  assign q_pop_o         = pop;
  assign out_valid_o     = out_valid_q;
  assign palette_index_o = index_q;

endmodule

[rtl/error_diffusion_palette_quantizer.sv]
// ----------------------------------------------------------------------------
// error_diffusion_palette_quantizer: dithered rgb to 216-color palette index
// path: queue, back stage register, output register; one item per clock sustained
// while items keep arriving and out_stall_i is low, set by the left-error feedback
// in the back stage; reset clears control, dither on and width 640; the row store is not cleared
// ----------------------------------------------------------------------------
`include "error_diffusion_palette_quantizer_macros.svh"

module error_diffusion_palette_quantizer #(
  parameter int MAX_WIDTH   = 2048,  // row store depth, widest legal row
  parameter int QUEUE_DEPTH = 4      // items between front and back
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [edpq_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [edpq_pkg::FW_W-1:0]         cfg_data_i,
  // pixel items in
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [edpq_pkg::CH_W-1:0]         red_i,
  input  logic [edpq_pkg::CH_W-1:0]         green_i,
  input  logic [edpq_pkg::CH_W-1:0]         blue_i,
  input  logic                              start_of_frame_i,
  // palette items out
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [edpq_pkg::INDEX_W-1:0]      palette_index_o
);

  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int Q_W    = $bits(edpq_pkg::pix_t) + $bits(edpq_pkg::flags_t) + ADDR_W;

  // configuration registers
  logic                      dither_q, dither_d;
  logic [edpq_pkg::FW_W-1:0] frame_width_q, frame_width_d;

  // front to queue
  edpq_pkg::pix_t            in_pix;
  logic                      push;
  edpq_pkg::pix_t            push_pix;
  edpq_pkg::flags_t          push_flags;
  logic [ADDR_W-1:0]         push_col;

  // queue to back
  logic [Q_W-1:0]            q_wdata, q_rdata;
  edpq_pkg::fifo_status_t    q_stat;
  logic                      pop;
  edpq_pkg::pix_t            q_pix;
  edpq_pkg::flags_t          q_flags;
  logic [ADDR_W-1:0]         q_col;

  // config always ready; user must write only while the block is idle, unchecked
  assign cfg_ready_o = 1'b1;

  always_comb begin
    dither_d      = dither_q;
    frame_width_d = frame_width_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        edpq_pkg::REG_DITHER_ENABLE: dither_d      = cfg_data_i[0];
        edpq_pkg::REG_FRAME_WIDTH:   frame_width_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dither_q      <= edpq_pkg::DITHER_RESET;
      frame_width_q <= edpq_pkg::FRAME_WIDTH_RESET;
    end else begin
      dither_q      <= dither_d;
      frame_width_q <= frame_width_d;
    end
  end

  assign in_pix.red   = red_i;
  assign in_pix.green = green_i;
  assign in_pix.blue  = blue_i;

  // front: column tracking and edge classification, stalls only on a full queue
  edpq_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .frame_width_i    (frame_width_q),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .start_of_frame_i (start_of_frame_i),
    .pix_i            (in_pix),
    .queue_full_i     (q_stat.full),
    .push_o           (push),
    .push_pix_o       (push_pix),
    .push_flags_o     (push_flags),
    .push_col_o       (push_col)
  );

  // queue decouples input stalls from output stalls
  assign q_wdata = {push_pix, push_flags, push_col};

  edpq_fifo #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (q_wdata),
    .pop_i    (pop),
    .data_o   (q_rdata),
    .status_o (q_stat)
  );

  assign {q_pix, q_flags, q_col} = q_rdata;

  // back: store read on pop, diffusion and quantize, store write and result
  edpq_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .dither_enable_i (dither_q),
    .q_empty_i       (q_stat.empty),
    .q_pix_i         (q_pix),
    .q_flags_i       (q_flags),
    .q_col_i         (q_col),
    .q_pop_o         (pop),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .palette_index_o (palette_index_o)
  );

  // queue is never pushed when full nor popped when empty
  `EDPQ_NEVER(a_push_full, clk_i, rst_ni, push && q_stat.full)
  `EDPQ_NEVER(a_pop_empty, clk_i, rst_ni, pop && q_stat.empty)
  // a result always names one of the 216 palette entries
  `EDPQ_ASSERT(a_index_range, clk_i, rst_ni, out_valid_o |-> (palette_index_o <= edpq_pkg::MAX_INDEX))

endmodule

[test/error_diffusion_palette_quantizer_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// error_diffusion_palette_quantizer_test
// feeds raster rgb pixel items through the quantizer with random input gaps
// and output stalls, predicts every palette index with its own model of the
// floyd-steinberg error carry, and checks the indexes in arrival order
// ----------------------------------------------------------------------------
module error_diffusion_palette_quantizer_test;
  import edpq_pkg::*;

  localparam int ROW_MAX      = 2048;  // row store depth of the instance
  localparam int QUIET_LIMIT  = 2000;  // cycles without any handshake
  localparam int RANDOM_ITEMS = 650;
  localparam int CALM_FROM    = 560;   // no idling from here to the end
  localparam int STEP         = 51;    // distance between palette levels

  // per-channel carried error, [0] red, [1] green, [2] blue, 6-bit signed
  typedef bit [2:0][5:0] err_trio_t;

  typedef struct packed {
    pix_t px;
    logic sof;
  } pixel_item_t;

  // clock, reset and block ports
  bit                    clk_i;
  logic                  rst_ni           = 1'b0;
  logic                  cfg_valid_i      = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i      = REG_DITHER_ENABLE;
  logic [FW_W-1:0]       cfg_data_i       = '0;
  logic                  in_valid_i       = 1'b0;
  logic                  in_stall_o;
  logic [CH_W-1:0]       red_i            = '0;
  logic [CH_W-1:0]       green_i          = '0;
  logic [CH_W-1:0]       blue_i           = '0;
  logic                  start_of_frame_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i      = 1'b0;
  logic [INDEX_W-1:0]    palette_index_o;

  // stimulus and expectations
  pixel_item_t         pending_pixels[$];
  logic [INDEX_W-1:0]  expected_indexes[$];
  pixel_item_t         next_pixel;
  logic [INDEX_W-1:0]  want_index;
  bit                  pix_accepted;
  int                  gap_left;
  int                  stall_left;
  int                  in_gap_pct;
  int                  out_stall_pct;
  int                  mismatch_count;
  int                  quiet_cycles;

  // predictor state, mirrors the block after reset
  err_trio_t           err_row [ROW_MAX];
  err_trio_t           left_err  = '0;
  err_trio_t           diag_err  = '0;   // upper-left carry
  int                  col_pos   = 0;
  bit                  top_row   = 1'b1;
  int                  cols_seen = 0;    // columns written since start of frame
  bit                  dither_on = DITHER_RESET;
  logic [FW_W-1:0]     width_reg = FRAME_WIDTH_RESET;

  error_diffusion_palette_quantizer #(
    .MAX_WIDTH(ROW_MAX)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .red_i           (red_i),
    .green_i         (green_i),
    .blue_i          (blue_i),
    .start_of_frame_i(start_of_frame_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .palette_index_o (palette_index_o)
  );

  // 12 ns period
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // ------------------------------------------------------------------------
  // prediction
  // ------------------------------------------------------------------------

  function automatic int clamp8(int v);
    return (v < 0) ? 0 : ((v > 255) ? 255 : v);
  endfunction

  // level thresholds: at or below goes to the lower level
  function automatic int cut_of(int k);
    case (k)
      0: return 26;
      1: return 76;
      2: return 128;
      3: return 178;
      default: return 230;
    endcase
  endfunction

  // register value 0 behaves as 1, anything above the store depth as the depth
  function automatic int eff_width(logic [FW_W-1:0] w);
    if (w == 0) return 1;
    if (w > ROW_MAX) return ROW_MAX;
    return w;
  endfunction

  // one pixel in, one palette index out; advances the carried errors
  function automatic logic [INDEX_W-1:0] dither_and_quantize(pix_t px, logic sof);
    int        w;
    int        j;
    int        v;
    int        lv;
    int        idx;
    int        chan [3];
    err_trio_t up;
    err_trio_t ur;
    err_trio_t ul;
    err_trio_t fresh;
    w       = eff_width(width_reg);
    chan[0] = px.red;
    chan[1] = px.green;
    chan[2] = px.blue;
    idx     = 0;
    fresh   = '0;
    // start of frame forgets the row above
    if (sof) begin
      col_pos   = 0;
      top_row   = 1'b1;
      cols_seen = 0;
    end
    // width shrank under the current column: begin a fresh row
    if (col_pos >= w) begin
      col_pos = 0;
      top_row = 1'b0;
    end
    j  = col_pos;
    up = err_row[j];
    ur = (j + 1 < w) ? err_row[j + 1] : '0;
    ul = diag_err;
    for (int ch = 0; ch < 3; ch++) begin
      v = chan[ch];
      if (dither_on) begin
        // contributions in order upper-left, above, upper-right, left,
        // each clamped before the next
        if (!top_row) begin
          if (j > 0) v = clamp8(v + $signed(ul[ch]) / 16);
          v = clamp8(v + 5 * $signed(up[ch]) / 16);
          if (j + 1 < w) v = clamp8(v + 3 * $signed(ur[ch]) / 16);
        end
        if (j > 0) v = clamp8(v + 7 * $signed(left_err[ch]) / 16);
      end
      lv = 0;
      for (int k = 0; k < 5; k++) if (v > cut_of(k)) lv++;
      if (dither_on) fresh[ch] = 6'(v - lv * STEP);
      idx = idx * 6 + lv;
    end
    diag_err   = up;
    err_row[j] = fresh;
    left_err   = fresh;
    if (j + 1 > cols_seen) cols_seen = j + 1;
    if (j + 1 >= w) begin
      col_pos = 0;
      top_row = 1'b0;
    end else begin
      col_pos = j + 1;
    end
    return INDEX_W'(idx);
  endfunction

  // ------------------------------------------------------------------------
  // pixel driver
  // ------------------------------------------------------------------------

  // sample the handshake and predict on every accepted item
  always @(posedge clk_i) begin
    pix_accepted = in_valid_i && !in_stall_o;
    if (pix_accepted)
      expected_indexes.push_back(
        dither_and_quantize({red_i, green_i, blue_i}, start_of_frame_i));
  end

  // present the next item once the current one is gone; a stalled item holds
  always @(negedge clk_i) begin
    if (!in_valid_i || pix_accepted) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_pixels.size() != 0 && in_gap_pct != 0 &&
                   $urandom_range(0, 99) < in_gap_pct) begin
        // gap burst, this one included; gap_left holds the rest of it
        gap_left = $urandom_range(0, 14);
        in_valid_i <= 1'b0;
      end else if (pending_pixels.size() != 0) begin
        next_pixel = pending_pixels.pop_front();
        in_valid_i       <= 1'b1;
        red_i            <= next_pixel.px.red;
        green_i          <= next_pixel.px.green;
        blue_i           <= next_pixel.px.blue;
        start_of_frame_i <= next_pixel.sof;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------------
  // index monitor
  // ------------------------------------------------------------------------

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (expected_indexes.size() == 0) begin
        report_mismatch($sformatf("palette index %0d with nothing expected",
                                  palette_index_o));
      end else begin
        want_index = expected_indexes.pop_front();
        if (palette_index_o !== want_index)
          report_mismatch($sformatf("palette index %0d, expected %0d",
                                    palette_index_o, want_index));
      end
    end
  end

  // receiver stalls in bursts; stall_left holds what is left of one
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
      stall_left = $urandom_range(0, 14);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // stimulus
  // ------------------------------------------------------------------------

  task automatic queue_pixel(int r, int g, int b, bit sof);
    pixel_item_t it;
    it.px.red   = r;
    it.px.green = g;
    it.px.blue  = b;
    it.sof      = sof;
    pending_pixels.push_back(it);
  endtask

  // mostly uniform, a quarter of values right around a threshold
  function automatic int pick_channel();
    if ($urandom_range(0, 3) == 0) return cut_of($urandom_range(0, 4)) + $urandom_range(0, 2) - 1;
    return $urandom_range(0, 255);
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 4;
      2: return 12;
      default: return 30;
    endcase
  endfunction

  // register write; the predictor takes the value on the accepting edge
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FW_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_DITHER_ENABLE) dither_on = val[0];
    else width_reg = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic setup(bit dither, logic [FW_W-1:0] w);
    write_reg(REG_DITHER_ENABLE, FW_W'(dither));
    write_reg(REG_FRAME_WIDTH, w);
  endtask

  // block is idle once every item went in and every index came out
  task automatic wait_idle();
    while (pending_pixels.size() != 0 || in_valid_i || expected_indexes.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    int              random_count;
    int              pick;
    int              w_eff;
    int              n;
    logic [FW_W-1:0] w;
    bit              d;
    bit              sof_first;
    random_count = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    in_gap_pct    = 10;
    out_stall_pct = 10;

    // four-wide rows: extremes, both sides of every threshold, three rows so
    // the upper-left, above, upper-right and left carries all show up, then a
    // start of frame in the middle of a row
    setup(1'b1, 12'd4);
    queue_pixel(0, 0, 0, 1'b1);
    queue_pixel(255, 255, 255, 1'b0);
    queue_pixel(26, 76, 128, 1'b0);
    queue_pixel(27, 77, 129, 1'b0);
    queue_pixel(178, 230, 26, 1'b0);
    queue_pixel(179, 231, 27, 1'b0);
    queue_pixel(128, 129, 230, 1'b0);
    queue_pixel(231, 0, 255, 1'b0);
    queue_pixel(100, 150, 200, 1'b0);
    queue_pixel(13, 60, 240, 1'b0);
    queue_pixel(50, 50, 50, 1'b0);
    queue_pixel(205, 25, 180, 1'b0);
    queue_pixel(60, 60, 60, 1'b0);
    queue_pixel(70, 70, 70, 1'b0);
    queue_pixel(77, 77, 77, 1'b1);
    wait_idle();

    // width zero acts as a single column: every pixel is its own row
    setup(1'b1, 12'd0);
    queue_pixel(40, 40, 40, 1'b1);
    queue_pixel(40, 40, 40, 1'b0);
    queue_pixel(200, 10, 120, 1'b0);
    queue_pixel(30, 220, 90, 1'b0);
    wait_idle();

    // dither off: plain quantization, no error recorded
    setup(1'b0, 12'd3);
    queue_pixel(25, 25, 25, 1'b1);
    queue_pixel(230, 231, 129, 1'b0);
    queue_pixel(0, 255, 77, 1'b0);
    queue_pixel(26, 27, 178, 1'b0);
    queue_pixel(179, 128, 76, 1'b0);
    queue_pixel(255, 0, 51, 1'b0);

    // random frames, a fresh setting each phase
    while (random_count < RANDOM_ITEMS) begin
      wait_idle();
      if (random_count >= CALM_FROM) begin
        in_gap_pct    = 0;
        out_stall_pct = 0;
      end else begin
        in_gap_pct    = pick_pct();
        out_stall_pct = pick_pct();
      end
      d    = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 19);
      case (pick)
        0: w = 12'd0;
        1: w = 12'd4095;
        2: w = FW_W'(ROW_MAX);
        3: w = 12'd640;
        4: w = 12'd1;
        default: w = FW_W'($urandom_range(2, 12));
      endcase
      w_eff = eff_width(w);
      // small widths get several rows and maybe a partial one; wide rows stay short
      if (w_eff <= 16) n = w_eff * $urandom_range(2, 6) + $urandom_range(0, w_eff - 1);
      else n = $urandom_range(20, 60);
      if (n > 90) n = 90;
      // without a start of frame the new rows may only read columns already
      // written in this frame; a narrower width keeps going mid-frame
      sof_first = (w_eff > cols_seen) || ($urandom_range(0, 1) == 1);
      setup(d, w);
      for (int i = 0; i < n; i++) begin
        queue_pixel(pick_channel(), pick_channel(), pick_channel(),
                    (i == 0 && sof_first) || ($urandom_range(0, 39) == 0));
        random_count++;
      end
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/edpq_pkg.sv
rtl/edpq_ram.sv
rtl/edpq_fifo.sv
rtl/edpq_front.sv
rtl/edpq_back.sv
rtl/error_diffusion_palette_quantizer.sv
test/error_diffusion_palette_quantizer_test.sv
